// ===== design/tdrle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdrle_pkg
// Types and constants shared by the timestamp delta run-length encoder.
// ----------------------------------------------------------------------------
package tdrle_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One incoming sample item.
  typedef struct packed {
    logic [31:0] timestamp;
    logic        first_sample;
    logic        last_sample;
  } sample_t;

  // One time-to-sample table entry.
  typedef struct packed {
    logic [COUNT_BITS-1:0] run_count;
    logic [31:0]           run_duration;
    logic                  final_entry;
  } entry_t;

endpackage : tdrle_pkg
`default_nettype wire

// ===== design/timestamp_delta_run_length_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_delta_run_length_encoder
// Turns a stream of presentation timestamps into (count, duration) runs of
// equal consecutive deltas, as in an MP4 time-to-sample table.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | item
//  ---------+----------------------------------+-----------+------------------
//  sample   | sample, sample_valid, sample_stall | in      | timestamp + flags
//  entry    | entry, entry_valid, entry_stall  | out       | one table entry
//
// Cycles: the delta, compare and run update happen in the cycle a sample is
// accepted; its 0, 1 or 2 entries are registered into a four-deep entry
// queue behind any older ones. One sample per cycle is taken while the queue
// has two free slots, one entry leaves per cycle while entry_stall is low.
// Reset (rst, synchronous, active high) clears run state and empties the queue.
// sample_stall depends only on queue fill, never on entry_stall directly.
//
module timestamp_delta_run_length_encoder
  import tdrle_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire sample_t sample,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  output entry_t       entry,
  output logic         entry_valid,
  input  wire logic    entry_stall
);

  // bits of the timestamp / duration that fit in 32
  localparam int unsigned NARROW_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_BITS-1:0] FILL_LIMIT = FILL_BITS'(QUEUE_DEPTH - 2);

  // run state
  logic [TIME_BITS-1:0]  previous_timestamp;
  logic [TIME_BITS-1:0]  open_duration;
  logic [COUNT_BITS-1:0] open_count;
  logic                  have_previous;
  logic                  have_open_run;

  // entry queue
  entry_t               queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  head;
  logic [PTR_BITS-1:0]  tail;
  logic [FILL_BITS-1:0] fill;

  logic                  sample_take;
  logic                  entry_take;
  logic [TIME_BITS-1:0]  ts;
  logic [TIME_BITS-1:0]  delta;
  logic                  seg_start;
  logic                  run_match;
  logic [COUNT_BITS-1:0] run_count_next;
  logic [TIME_BITS-1:0]  run_duration_next;
  logic                  close_push;
  logic                  final_push;
  entry_t                close_entry;
  entry_t                final_entry_w;
  logic [FILL_BITS-1:0]  push_count;

  assign sample_take = sample_valid && !sample_stall;
  assign entry_take  = entry_valid && !entry_stall;

  assign sample_stall = (fill > FILL_LIMIT);
  assign entry_valid  = (fill != '0);
  assign entry        = queue[head];

  // only the low TIME_BITS of the timestamp count
  assign ts    = TIME_BITS'(sample.timestamp[NARROW_BITS-1:0]);
  assign delta = ts - previous_timestamp;

  // a sample without a predecessor opens a segment whatever its flag says
  assign seg_start = sample.first_sample || !have_previous;
  assign run_match = have_open_run && (delta == open_duration);

  always_comb begin
    if (run_match) begin
      run_count_next    = (open_count == COUNT_MAX) ? open_count : open_count + 1'b1;
      run_duration_next = open_duration;
    end else begin
      run_count_next    = COUNT_BITS'(1);
      run_duration_next = delta;
    end
  end

  // delta changed: the old run closes
  assign close_push = !seg_start && have_open_run && !run_match;
  // last sample: flush whatever run is open after this one
  assign final_push = !seg_start && sample.last_sample;

  assign close_entry.run_count    = open_count;
  assign close_entry.run_duration = 32'(open_duration[NARROW_BITS-1:0]);
  assign close_entry.final_entry  = 1'b0;

  assign final_entry_w.run_count    = run_count_next;
  assign final_entry_w.run_duration = 32'(run_duration_next[NARROW_BITS-1:0]);
  assign final_entry_w.final_entry  = 1'b1;

  assign push_count = sample_take
                    ? (FILL_BITS'(close_push) + FILL_BITS'(final_push)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_timestamp <= '0;
      open_duration      <= '0;
      open_count         <= '0;
      have_previous      <= 1'b0;
      have_open_run      <= 1'b0;
    end else if (sample_take) begin
      previous_timestamp <= ts;
      if (seg_start) begin
        have_previous <= !sample.last_sample;
        have_open_run <= 1'b0;
        open_count    <= '0;
        open_duration <= '0;
      end else if (sample.last_sample) begin
        have_previous <= 1'b0;
        have_open_run <= 1'b0;
        open_count    <= '0;
        open_duration <= '0;
      end else begin
        have_open_run <= 1'b1;
        open_count    <= run_count_next;
        open_duration <= run_duration_next;
      end
    end
  end

  // queue payload: no reset needed
  always_ff @(posedge clk) begin
    if (sample_take) begin
      if (close_push) begin
        queue[tail] <= close_entry;
        if (final_push) begin
          queue[tail + 1'b1] <= final_entry_w;
        end
      end else if (final_push) begin
        queue[tail] <= final_entry_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + PTR_BITS'(push_count);
      if (entry_take) begin
        head <= head + 1'b1;
      end
      fill <= fill + push_count - FILL_BITS'(entry_take);
    end
  end

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(QUEUE_DEPTH))
    else $error("entry queue overfilled");

  a_start_no_entry : assert property (@(posedge clk) disable iff (rst)
    (sample_take && seg_start) |=> (fill == $past(fill) - FILL_BITS'($past(entry_take))))
    else $error("segment start produced an entry");

  a_last_ends_segment : assert property (@(posedge clk) disable iff (rst)
    (sample_take && sample.last_sample) |=> (!have_previous && !have_open_run))
    else $error("segment still open after last sample");

  a_final_pushes : assert property (@(posedge clk) disable iff (rst)
    (sample_take && !seg_start && sample.last_sample) |=> entry_valid)
    else $error("final run not queued");

endmodule : timestamp_delta_run_length_encoder
`default_nettype wire

// ===== verif/timestamp_delta_run_length_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamp_delta_run_length_encoder_test
// Self-checking bench for the timestamp delta run-length encoder. A short
// table of hand-picked samples opens the run (missing segment starts,
// single-sample segments, restarts in mid-segment, wrap-around deltas, double
// emits), then random segments follow. Every table entry is compared with a
// behavioural run encoder kept inside the bench, or with entries typed by hand.
// ----------------------------------------------------------------------------
module timestamp_delta_run_length_encoder_test;

  import tdrle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SEGMENT_BUDGET = 560;   // samples per random phase
  localparam int unsigned HOLD_CYCLES  = 300;     // long entry hold-off
  localparam entry_t      NO_ENTRY     = '0;

  // One row of the directed table. Where typed is set, the entries are
  // written out by hand and the run encoder below only tracks state.
  typedef struct packed {
    sample_t    smp;
    logic       typed;
    logic [1:0] n;
    entry_t     e0;
    entry_t     e1;
  } stim_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  sample_t sample       = '0;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  entry_t  entry;
  logic    entry_valid;
  logic    entry_stall  = 1'b0;

  always #5 clk = ~clk;

  timestamp_delta_run_length_encoder #(
    .TIME_BITS (32)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .entry        (entry),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall)
  );

  // --------------------------------------------------------------------------
  // Behavioural run encoder: mirrors the block's state and queues the table
  // entries each accepted sample should produce, oldest first.
  // --------------------------------------------------------------------------
  logic [31:0] last_ts;
  logic [31:0] run_dur;
  logic [31:0] run_cnt;
  logic        seen_prev = 1'b0;
  logic        run_open  = 1'b0;

  entry_t    entries_due[$];
  stim_row_t directed_rows[$];

  int unsigned failures           = 0;
  int unsigned entries_checked    = 0;
  int unsigned items_sent         = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned cycle_count        = 0;
  int unsigned send_idle_pct      = 10;
  int unsigned recv_stall_pct     = 88;
  int unsigned hold_left          = 0;
  logic        hold_request       = 1'b0;
  entry_t      want;

  function automatic void encode_sample(input sample_t s, input logic keep);
    logic [31:0] delta;
    // A sample opens a segment when flagged, or when no segment is running
    // (after reset or after a flushed one): nothing comes out.
    if (s.first_sample || !seen_prev) begin
      last_ts   = s.timestamp;
      seen_prev = !s.last_sample;
      run_open  = 1'b0;
      run_cnt   = '0;
      run_dur   = '0;
      return;
    end
    delta = s.timestamp - last_ts;          // wraps modulo 2^32
    if (run_open && delta == run_dur) begin
      if (run_cnt != COUNT_MAX)
        run_cnt = run_cnt + 32'd1;
    end else begin
      if (run_open && keep)
        entries_due.push_back(entry_t'{run_cnt, run_dur, 1'b0});
      run_dur  = delta;
      run_cnt  = 32'd1;
      run_open = 1'b1;
    end
    last_ts = s.timestamp;
    if (s.last_sample) begin
      if (keep)
        entries_due.push_back(entry_t'{run_cnt, run_dur, 1'b1});
      run_open  = 1'b0;
      seen_prev = 1'b0;
      run_cnt   = '0;
      run_dur   = '0;
    end
  endfunction

  function automatic void add_row(input logic [31:0] ts, input logic fs, input logic ls);
    directed_rows.push_back(stim_row_t'{sample_t'{ts, fs, ls}, 1'b0, 2'd0,
                                        NO_ENTRY, NO_ENTRY});
  endfunction

  function automatic void add_row_typed(input logic [31:0] ts, input logic fs,
                                        input logic ls, input logic [1:0] n,
                                        input entry_t e0, input entry_t e1);
    directed_rows.push_back(stim_row_t'{sample_t'{ts, fs, ls}, 1'b1, n, e0, e1});
  endfunction

  // Random delta: zero, all-ones (a step of -1), a typical frame duration,
  // a small jitter value or anything at all.
  function automatic logic [31:0] pick_delta();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1001;
      3:       return $urandom_range(1, 4000);
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sample side. Idle gaps come first, then the item is offered and held until
  // taken. Valid stays high from one item into the next unless an idle gap comes.
  // --------------------------------------------------------------------------
  task automatic send_sample(input sample_t s, input logic keep);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall)
      @(posedge clk);
    items_sent++;
    encode_sample(s, keep);
  endtask

  // Mostly well-formed segments: first mark, runs of a constant delta with
  // random length, last mark. About one pick in eight is a lone sample with
  // random flags; a few segments lose their first mark or are cut short,
  // so the next first mark lands mid-segment.
  task automatic run_random_segments(input int unsigned budget);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned run_left;
    int unsigned roll;
    logic [31:0] ts;
    logic [31:0] delta;
    sample_t     s;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        s.timestamp    = $urandom;
        s.first_sample = 1'($urandom_range(1));
        s.last_sample  = 1'($urandom_range(1));
        send_sample(s, 1'b1);
        sent++;
      end else begin
        seg_len  = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 12);
        ts       = $urandom;
        delta    = pick_delta();
        run_left = $urandom_range(1, 5);
        for (int unsigned k = 0; k < seg_len; k++) begin
          if (k > 0) begin
            if (run_left == 0) begin
              delta    = pick_delta();
              run_left = ($urandom_range(7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 5);
            end
            run_left--;
            ts = ts + delta;
          end
          s.timestamp    = ts;
          s.first_sample = (k == 0) && (roll >= 16);
          s.last_sample  = (k == seg_len - 1) && (roll < 92);
          send_sample(s, 1'b1);
          sent++;
        end
      end
    end
  endtask

  // Sender stands back until every due entry has come out.
  task automatic wait_drained(input int unsigned settle);
    sample_valid <= 1'b0;
    while (entries_due.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Entry side: check on every accepted entry, then pick the next stall.
  // A hold request pins stall high for the long hold-off, so the entry queue
  // fills and the block has to push back on samples.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_stall)
        input_stall_cycles++;
      if (entry_valid && !entry_stall) begin
        if (entries_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: entry with none due: count %0d duration %h final %b",
                     $realtime, entry.run_count, entry.run_duration, entry.final_entry);
        end else begin
          want = entries_due.pop_front();
          if (entry.run_count !== want.run_count ||
              entry.run_duration !== want.run_duration ||
              entry.final_entry !== want.final_entry) begin
            failures++;
            if (failures <= 10)
              $display("%0t: entry mismatch: expected count %0d duration %h final %b, %s",
                       $realtime, want.run_count, want.run_duration, want.final_entry,
                       $sformatf("got count %0d duration %h final %b",
                                 entry.run_count, entry.run_duration, entry.final_entry));
          end
          entries_checked++;
        end
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      entry_stall <= 1'b1;
    end else begin
      entry_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;

    // Directed table. Run counts cannot reach saturation in a simulation of
    // this length, so that case is left to the run encoder's own logic.
    add_row_typed(32'd0, 1'b0, 1'b0, 2'd0, NO_ENTRY, NO_ENTRY); // no start mark after reset
    add_row      (32'd10, 1'b0, 1'b0);
    add_row      (32'd20, 1'b0, 1'b0);
    add_row_typed(32'd25, 1'b0, 1'b0, 2'd1, entry_t'{32'd2, 32'd10, 1'b0}, NO_ENTRY);
    add_row_typed(32'd30, 1'b0, 1'b1, 2'd1, entry_t'{32'd2, 32'd5, 1'b1}, NO_ENTRY);
    add_row_typed(32'hFFFF_FFFF, 1'b1, 1'b1, 2'd0, NO_ENTRY, NO_ENTRY); // lone sample
    add_row_typed(32'd5, 1'b0, 1'b0, 2'd0, NO_ENTRY, NO_ENTRY); // no start mark after a flush
    add_row      (32'd4, 1'b0, 1'b0);                            // delta wraps to all-ones
    add_row_typed(32'd3, 1'b0, 1'b1, 2'd1,
                  entry_t'{32'd2, 32'hFFFF_FFFF, 1'b1}, NO_ENTRY);
    add_row      (32'd100, 1'b1, 1'b0);
    add_row      (32'd100, 1'b0, 1'b0);                          // zero delta
    add_row_typed(32'd200, 1'b0, 1'b0, 2'd1, entry_t'{32'd1, 32'd0, 1'b0}, NO_ENTRY);
    add_row_typed(32'd300, 1'b1, 1'b0, 2'd0, NO_ENTRY, NO_ENTRY); // restart drops open run
    add_row_typed(32'd300, 1'b0, 1'b1, 2'd1, entry_t'{32'd1, 32'd0, 1'b1}, NO_ENTRY);
    add_row      (32'd0, 1'b1, 1'b0);
    add_row      (32'd7, 1'b0, 1'b0);
    add_row_typed(32'hFFFF_FFFF, 1'b0, 1'b1, 2'd2,              // closed run plus flush
                  entry_t'{32'd1, 32'd7, 1'b0}, entry_t'{32'd1, 32'hFFFF_FFF8, 1'b1});
    add_row_typed(32'hAAAA_5555, 1'b1, 1'b1, 2'd0, NO_ENTRY, NO_ENTRY);
    add_row      (32'h8000_0000, 1'b1, 1'b0);
    add_row_typed(32'h7FFF_FFFF, 1'b0, 1'b1, 2'd1,
                  entry_t'{32'd1, 32'hFFFF_FFFF, 1'b1}, NO_ENTRY);
    add_row      (32'd1, 1'b1, 1'b0);
    add_row      (32'd2, 1'b0, 1'b0);
    add_row_typed(32'd9, 1'b1, 1'b1, 2'd0, NO_ENTRY, NO_ENTRY);  // lone sample mid-segment
    add_row_typed(32'h5555_AAAA, 1'b0, 1'b1, 2'd0, NO_ENTRY, NO_ENTRY); // unmarked lone

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender rarely idles, receiver mostly stalls.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_sample(row.smp, !row.typed);
      if (row.typed && row.n > 0)
        entries_due.push_back(row.e0);
      if (row.typed && row.n > 1)
        entries_due.push_back(row.e1);
    end
    run_random_segments(SEGMENT_BUDGET);
    wait_drained(4);

    // Phase two: the other way round.
    send_idle_pct  = 88;
    recv_stall_pct = 10;
    run_random_segments(SEGMENT_BUDGET);
    wait_drained(4);

    // Phase three: full rate both ways, opening with a long receiver hold.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    run_random_segments(SEGMENT_BUDGET);
    wait_drained(20);

    if (entries_due.size() != 0) begin
      $display("%0d entries never arrived", entries_due.size());
      failures += entries_due.size();
    end
    $display("Covered %0d samples (directed table plus random segments), %0d entries checked,",
             items_sent, entries_checked);
    $display("sample input pushed back for %0d cycles, %0d failures",
             input_stall_cycles, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
